// ----- rtl/afc_pkg.sv -----
// Shared constants, codes and types of the ASCII formula calculator.
// Used by the top level, the multiply/divide unit and the port checker.
// No dependencies.
package afc_pkg;

    // Value width of the arithmetic; the answer port is always 32 bits
    localparam int VALUE_BITS  = 32;
    localparam int ANSWER_BITS = 32;
    localparam int STATUS_BITS = 3;
    localparam int CNT_BITS    = $clog2(VALUE_BITS);

    // Status codes
    localparam logic [STATUS_BITS-1:0] STATUS_OK          = 3'd0;
    localparam logic [STATUS_BITS-1:0] STATUS_NO_OPERAND  = 3'd1;
    localparam logic [STATUS_BITS-1:0] STATUS_BAD_OP      = 3'd2;
    localparam logic [STATUS_BITS-1:0] STATUS_DIV_ZERO    = 3'd3;
    localparam logic [STATUS_BITS-1:0] STATUS_NO_SECOND   = 3'd4;

    // Characters
    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_SLASH = 8'h2F;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_TIMES = 8'h78;

    // Token phases
    localparam logic [2:0] TP_BEFORE = 3'd0;
    localparam logic [2:0] TP_FIRST  = 3'd1;
    localparam logic [2:0] TP_GAP1   = 3'd2;
    localparam logic [2:0] TP_OP     = 3'd3;
    localparam logic [2:0] TP_GAP2   = 3'd4;
    localparam logic [2:0] TP_SECOND = 3'd5;
    localparam logic [2:0] TP_AFTER  = 3'd6;

    // Number phases
    localparam logic [1:0] NP_SKIP   = 2'd0;
    localparam logic [1:0] NP_SIGN   = 2'd1;
    localparam logic [1:0] NP_DIGITS = 2'd2;
    localparam logic [1:0] NP_DONE   = 2'd3;

    localparam logic [2:0] STOP_LEN = 3'd4;

    // Request and response between the top level and the multiply/divide unit
    typedef struct packed {
        logic start;
        logic is_div;
    } md_req_t;

    typedef struct packed {
        logic                  done;
        logic [VALUE_BITS-1:0] value;
    } md_rsp_t;

    // Letters of the stop word
    function automatic logic [7:0] stop_char(input logic [1:0] idx);
        logic [7:0] ch;
        case (idx)
            2'd0:    ch = 8'h53;
            2'd1:    ch = 8'h54;
            2'd2:    ch = 8'h4F;
            default: ch = 8'h50;
        endcase
        return ch;
    endfunction

endpackage

// ----- rtl/ascii_formula_calculator.sv -----
// Top level of the ASCII formula calculator: byte parser, evaluation
// sequencer and output register. Depends on afc_pkg and afc_muldiv.
//
// Channel  Direction  Handshake          Payload
// in       input      in_valid/in_stall  text_byte, end_of_message
// out      output     out_valid/out_stall answer, status, stop_request
//
// A byte that does not end the message is taken without stalling the input.
// The final byte stalls the input through the closing and evaluation states, and for
// multiply and divide also while the one-bit-per-cycle multiply/divide unit works;
// the result beat shows as the input opens.
// A result waiting in the output register leaves the input open; only the
// evaluation of the next message waits until that beat is taken.
// Reset clears all parse state and leaves the block waiting for a byte.
module ascii_formula_calculator (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    output logic                            in_stall,
    input  logic [7:0]                      text_byte,
    input  logic                            end_of_message,
    output logic                            out_valid,
    input  logic                            out_stall,
    output logic signed [afc_pkg::ANSWER_BITS-1:0] answer,
    output logic [afc_pkg::STATUS_BITS-1:0] status,
    output logic                            stop_request
);

    localparam int VB = afc_pkg::VALUE_BITS;

    typedef enum logic [3:0] {
        ST_RUN  = 4'b0001,
        ST_FIN  = 4'b0010,
        ST_EVAL = 4'b0100,
        ST_WAIT = 4'b1000
    } calc_state_t;

    calc_state_t                       state_reg, state_next;
    logic [2:0]                        tp_reg, tp_next;
    logic [1:0]                        np_reg, np_next;
    logic                              neg_reg, neg_next;
    logic [VB-1:0]                     first_reg, first_next;
    logic [VB-1:0]                     second_reg, second_next;
    logic [7:0]                        op_reg, op_next;
    logic [2:0]                        stop_cnt_reg, stop_cnt_next;
    logic                              stop_miss_reg, stop_miss_next;
    logic                              ended_reg, ended_next;
    logic                              out_full_reg, out_full_next;

    logic signed [afc_pkg::ANSWER_BITS-1:0] answer_reg, answer_next;
    logic [afc_pkg::STATUS_BITS-1:0]   status_reg, status_next;
    logic                              stop_reg, stop_next;

    afc_pkg::md_req_t                  md_req;
    afc_pkg::md_rsp_t                  md_rsp;

    logic                              take;
    logic                              feed;
    logic                              is_ws, is_digit;
    logic [3:0]                        digit_val;
    logic                              fresh, sel_second;
    logic [VB-1:0]                     acc_in, acc_x10;
    logic [1:0]                        np_in;
    logic                              neg_in;
    logic [VB-1:0]                     num_acc;
    logic [1:0]                        num_np;
    logic                              num_neg;
    logic [VB-1:0]                     fin_src, fin_neg;
    logic [VB-1:0]                     addsub;
    logic [afc_pkg::STATUS_BITS-1:0]   eval_status;
    logic                              use_unit;

    assign take      = in_valid && !in_stall;
    assign feed      = !ended_reg && (text_byte != afc_pkg::CH_NUL);
    assign is_ws     = (text_byte == afc_pkg::CH_SPACE)
                       || (text_byte inside {[afc_pkg::CH_TAB:afc_pkg::CH_CR]});
    assign is_digit  = text_byte inside {[afc_pkg::CH_ZERO:afc_pkg::CH_NINE]};
    assign digit_val = 4'(text_byte - afc_pkg::CH_ZERO);

    // Select the number being built; a new token starts from zero
    assign fresh      = (tp_reg == afc_pkg::TP_BEFORE) || (tp_reg == afc_pkg::TP_GAP2);
    assign sel_second = (tp_reg == afc_pkg::TP_GAP2) || (tp_reg == afc_pkg::TP_SECOND);
    assign acc_in     = fresh ? '0 : (sel_second ? second_reg : first_reg);
    assign np_in      = fresh ? afc_pkg::NP_SKIP : np_reg;
    assign neg_in     = fresh ? 1'b0 : neg_reg;
    assign acc_x10    = {acc_in[VB-4:0], 3'b000} + {acc_in[VB-2:0], 1'b0}
                        + VB'(digit_val);

    // Apply one character to the number scanner
    always_comb
    begin
        num_acc = acc_in;
        num_np  = np_in;
        num_neg = neg_in;
        case (np_in)
            afc_pkg::NP_SKIP:
            begin
                if (is_ws)
                begin
                    num_np = afc_pkg::NP_SKIP;
                end
                else if ((text_byte == afc_pkg::CH_PLUS)
                         || (text_byte == afc_pkg::CH_MINUS))
                begin
                    num_neg = (text_byte == afc_pkg::CH_MINUS);
                    num_np  = afc_pkg::NP_SIGN;
                end
                else if (is_digit)
                begin
                    num_acc = acc_x10;
                    num_np  = afc_pkg::NP_DIGITS;
                end
                else
                begin
                    num_np = afc_pkg::NP_DONE;
                end
            end
            afc_pkg::NP_SIGN, afc_pkg::NP_DIGITS:
            begin
                if (is_digit)
                begin
                    num_acc = acc_x10;
                    num_np  = afc_pkg::NP_DIGITS;
                end
                else
                begin
                    num_np = afc_pkg::NP_DONE;
                end
            end
            default:
            begin
                num_np = afc_pkg::NP_DONE;
            end
        endcase
    end

    // Negate the number of the token being closed
    assign fin_src = (tp_reg == afc_pkg::TP_SECOND) ? second_reg : first_reg;
    assign fin_neg = VB'(0) - fin_src;

    // Plus and minus share one adder
    assign addsub = (op_reg == afc_pkg::CH_MINUS) ? (first_reg - second_reg)
                                                  : (first_reg + second_reg);

    // Classify the formula once both numbers are final
    always_comb
    begin
        eval_status = afc_pkg::STATUS_OK;
        use_unit    = 1'b0;
        if (tp_reg < afc_pkg::TP_OP)
        begin
            eval_status = afc_pkg::STATUS_NO_OPERAND;
        end
        else if (tp_reg < afc_pkg::TP_SECOND)
        begin
            eval_status = afc_pkg::STATUS_NO_SECOND;
        end
        else
        begin
            case (op_reg)
                afc_pkg::CH_PLUS, afc_pkg::CH_MINUS:
                begin
                    eval_status = afc_pkg::STATUS_OK;
                end
                afc_pkg::CH_TIMES:
                begin
                    use_unit = 1'b1;
                end
                afc_pkg::CH_SLASH:
                begin
                    if (second_reg == '0)
                    begin
                        eval_status = afc_pkg::STATUS_DIV_ZERO;
                    end
                    else
                    begin
                        use_unit = 1'b1;
                    end
                end
                default:
                begin
                    eval_status = afc_pkg::STATUS_BAD_OP;
                end
            endcase
        end
    end

    assign md_req.start  = (state_reg == ST_EVAL) && !out_full_reg && use_unit;
    assign md_req.is_div = (op_reg == afc_pkg::CH_SLASH);

    afc_muldiv u_muldiv (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (md_req),
        .a     (first_reg),
        .b     (second_reg),
        .rsp   (md_rsp)
    );

    // Sequence parsing, evaluation and the result beat
    always_comb
    begin
        state_next     = state_reg;
        tp_next        = tp_reg;
        np_next        = np_reg;
        neg_next       = neg_reg;
        first_next     = first_reg;
        second_next    = second_reg;
        op_next        = op_reg;
        stop_cnt_next  = stop_cnt_reg;
        stop_miss_next = stop_miss_reg;
        ended_next     = ended_reg;
        answer_next    = answer_reg;
        status_next    = status_reg;
        stop_next      = stop_reg;
        out_full_next  = out_full_reg;
        // Drop the result beat once it is taken
        if (out_full_reg && !out_stall)
        begin
            out_full_next = 1'b0;
        end
        case (state_reg)
            ST_RUN:
            begin
                if (take)
                begin
                    if (!ended_reg && (text_byte == afc_pkg::CH_NUL))
                    begin
                        ended_next = 1'b1;
                    end
                    if (feed)
                    begin
                        // Track the stop word
                        if (!stop_miss_reg)
                        begin
                            if ((stop_cnt_reg < afc_pkg::STOP_LEN)
                                && (text_byte == afc_pkg::stop_char(stop_cnt_reg[1:0])))
                            begin
                                stop_cnt_next = stop_cnt_reg + 1'b1;
                            end
                            else
                            begin
                                stop_miss_next = 1'b1;
                            end
                        end
                        if (text_byte == afc_pkg::CH_SPACE)
                        begin
                            // Close the current token
                            case (tp_reg)
                                afc_pkg::TP_FIRST:
                                begin
                                    if (neg_reg)
                                    begin
                                        first_next = fin_neg;
                                    end
                                    neg_next = 1'b0;
                                    np_next  = afc_pkg::NP_DONE;
                                    tp_next  = afc_pkg::TP_GAP1;
                                end
                                afc_pkg::TP_OP:
                                begin
                                    tp_next = afc_pkg::TP_GAP2;
                                end
                                afc_pkg::TP_SECOND:
                                begin
                                    if (neg_reg)
                                    begin
                                        second_next = fin_neg;
                                    end
                                    neg_next = 1'b0;
                                    np_next  = afc_pkg::NP_DONE;
                                    tp_next  = afc_pkg::TP_AFTER;
                                end
                                default:
                                begin
                                    tp_next = tp_reg;
                                end
                            endcase
                        end
                        else
                        begin
                            // Extend the current token
                            case (tp_reg)
                                afc_pkg::TP_BEFORE, afc_pkg::TP_FIRST:
                                begin
                                    first_next = num_acc;
                                    np_next    = num_np;
                                    neg_next   = num_neg;
                                    tp_next    = afc_pkg::TP_FIRST;
                                end
                                afc_pkg::TP_GAP1:
                                begin
                                    op_next = text_byte;
                                    tp_next = afc_pkg::TP_OP;
                                end
                                afc_pkg::TP_GAP2, afc_pkg::TP_SECOND:
                                begin
                                    second_next = num_acc;
                                    np_next     = num_np;
                                    neg_next    = num_neg;
                                    tp_next     = afc_pkg::TP_SECOND;
                                end
                                default:
                                begin
                                    tp_next = tp_reg;
                                end
                            endcase
                        end
                    end
                    if (end_of_message)
                    begin
                        state_next = ST_FIN;
                    end
                end
            end
            ST_FIN:
            begin
                // Close a number token left open by the final byte
                if (tp_reg == afc_pkg::TP_FIRST)
                begin
                    if (neg_reg)
                    begin
                        first_next = fin_neg;
                    end
                    neg_next = 1'b0;
                    np_next  = afc_pkg::NP_DONE;
                end
                else if (tp_reg == afc_pkg::TP_SECOND)
                begin
                    if (neg_reg)
                    begin
                        second_next = fin_neg;
                    end
                    neg_next = 1'b0;
                    np_next  = afc_pkg::NP_DONE;
                end
                state_next = ST_EVAL;
            end
            ST_EVAL:
            begin
                // Hold until the output register is free
                if (!out_full_reg)
                begin
                    stop_next   = !stop_miss_reg && (stop_cnt_reg == afc_pkg::STOP_LEN);
                    status_next = eval_status;
                    if ((eval_status == afc_pkg::STATUS_OK) && !use_unit)
                    begin
                        answer_next = afc_pkg::ANSWER_BITS'($signed(addsub));
                    end
                    else
                    begin
                        answer_next = '0;
                    end
                    out_full_next = !use_unit;
                    state_next    = use_unit ? ST_WAIT : ST_RUN;
                    // Drop the parse state for the next message
                    tp_next        = afc_pkg::TP_BEFORE;
                    np_next        = afc_pkg::NP_SKIP;
                    neg_next       = 1'b0;
                    first_next     = '0;
                    second_next    = '0;
                    op_next        = afc_pkg::CH_NUL;
                    stop_cnt_next  = '0;
                    stop_miss_next = 1'b0;
                    ended_next     = 1'b0;
                end
            end
            ST_WAIT:
            begin
                if (md_rsp.done)
                begin
                    answer_next   = afc_pkg::ANSWER_BITS'($signed(md_rsp.value));
                    out_full_next = 1'b1;
                    state_next    = ST_RUN;
                end
            end
            default:
            begin
                state_next = ST_RUN;
            end
        endcase
    end

    // Hold control and parse state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_RUN;
            tp_reg        <= afc_pkg::TP_BEFORE;
            np_reg        <= afc_pkg::NP_SKIP;
            neg_reg       <= 1'b0;
            first_reg     <= '0;
            second_reg    <= '0;
            op_reg        <= afc_pkg::CH_NUL;
            stop_cnt_reg  <= '0;
            stop_miss_reg <= 1'b0;
            ended_reg     <= 1'b0;
            out_full_reg  <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            tp_reg        <= tp_next;
            np_reg        <= np_next;
            neg_reg       <= neg_next;
            first_reg     <= first_next;
            second_reg    <= second_next;
            op_reg        <= op_next;
            stop_cnt_reg  <= stop_cnt_next;
            stop_miss_reg <= stop_miss_next;
            ended_reg     <= ended_next;
            out_full_reg  <= out_full_next;
        end
    end

    // Hold the result beat
    always_ff @(posedge clk)
    begin
        answer_reg <= answer_next;
        status_reg <= status_next;
        stop_reg   <= stop_next;
    end

    assign in_stall     = (state_reg != ST_RUN);
    assign out_valid    = out_full_reg;
    assign answer       = answer_reg;
    assign status       = status_reg;
    assign stop_request = stop_reg;

endmodule

// ----- rtl/afc_muldiv.sv -----
// Iterative multiply/divide unit: one shared adder, one bit per cycle.
// Signed truncating divide by sign-magnitude; multiply keeps the low bits.
// Depends on afc_pkg.
module afc_muldiv (
    input  logic                           clk,
    input  logic                           rst_n,
    input  afc_pkg::md_req_t               req,
    input  logic [afc_pkg::VALUE_BITS-1:0] a,
    input  logic [afc_pkg::VALUE_BITS-1:0] b,
    output afc_pkg::md_rsp_t               rsp
);

    localparam int W = afc_pkg::VALUE_BITS;

    typedef enum logic [2:0] {
        U_IDLE = 3'b001,
        U_STEP = 3'b010,
        U_SIGN = 3'b100
    } unit_state_t;

    unit_state_t                    state_reg, state_next;
    logic                           is_div_reg, is_div_next;
    logic                           neg_reg, neg_next;
    logic [afc_pkg::CNT_BITS-1:0]   cnt_reg, cnt_next;
    logic [W-1:0]                   rem_reg, rem_next;
    logic [W-1:0]                   quo_reg, quo_next;
    logic [W-1:0]                   opd_reg, opd_next;

    logic [W:0]                     add_a, add_b;
    logic                           add_cin;
    logic [W+1:0]                   add_sum;
    logic [W-1:0]                   a_mag, b_mag, pick;

    // Shared adder: subtract trial for divide, accumulate for multiply
    always_comb
    begin
        if (is_div_reg)
        begin
            add_a   = {rem_reg, quo_reg[W-1]};
            add_b   = ~{1'b0, opd_reg};
            add_cin = 1'b1;
        end
        else
        begin
            add_a   = {1'b0, rem_reg};
            add_b   = {1'b0, opd_reg};
            add_cin = 1'b0;
        end
        add_sum = {1'b0, add_a} + {1'b0, add_b} + (W+2)'(add_cin);
    end

    assign a_mag = a[W-1] ? (W'(0) - a) : a;
    assign b_mag = b[W-1] ? (W'(0) - b) : b;
    assign pick  = is_div_reg ? quo_reg : rem_reg;

    // Result is valid in the sign-fix cycle
    assign rsp.done  = (state_reg == U_SIGN);
    assign rsp.value = neg_reg ? (W'(0) - pick) : pick;

    // Sequence load, bit steps and sign fix
    always_comb
    begin
        state_next  = state_reg;
        is_div_next = is_div_reg;
        neg_next    = neg_reg;
        cnt_next    = cnt_reg;
        rem_next    = rem_reg;
        quo_next    = quo_reg;
        opd_next    = opd_reg;
        case (state_reg)
            U_IDLE:
            begin
                if (req.start)
                begin
                    is_div_next = req.is_div;
                    cnt_next    = afc_pkg::CNT_BITS'(W - 1);
                    rem_next    = '0;
                    if (req.is_div)
                    begin
                        neg_next = a[W-1] ^ b[W-1];
                        quo_next = a_mag;
                        opd_next = b_mag;
                    end
                    else
                    begin
                        neg_next = 1'b0;
                        quo_next = b;
                        opd_next = a;
                    end
                    state_next = U_STEP;
                end
            end
            U_STEP:
            begin
                if (is_div_reg)
                begin
                    if (add_sum[W+1])
                    begin
                        rem_next = add_sum[W-1:0];
                    end
                    else
                    begin
                        rem_next = add_a[W-1:0];
                    end
                    quo_next = {quo_reg[W-2:0], add_sum[W+1]};
                end
                else
                begin
                    if (quo_reg[0])
                    begin
                        rem_next = add_sum[W-1:0];
                    end
                    quo_next = {1'b0, quo_reg[W-1:1]};
                    opd_next = {opd_reg[W-2:0], 1'b0};
                end
                cnt_next = cnt_reg - 1'b1;
                if (cnt_reg == '0)
                begin
                    state_next = U_SIGN;
                end
            end
            U_SIGN:
            begin
                state_next = U_IDLE;
            end
            default:
            begin
                state_next = U_IDLE;
            end
        endcase
    end

    // Hold control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= U_IDLE;
            is_div_reg <= 1'b0;
            neg_reg    <= 1'b0;
            cnt_reg    <= '0;
        end
        else
        begin
            state_reg  <= state_next;
            is_div_reg <= is_div_next;
            neg_reg    <= neg_next;
            cnt_reg    <= cnt_next;
        end
    end

    // Hold operands and partial results
    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        opd_reg <= opd_next;
    end

endmodule

// ----- rtl/afc_checker.sv -----
// Port-level checker for the ASCII formula calculator, bound to the top level.
// Depends on afc_pkg and ascii_formula_calculator.
module afc_checker (
    input logic                                   clk,
    input logic                                   rst_n,
    input logic                                   in_valid,
    input logic                                   in_stall,
    input logic                                   end_of_message,
    input logic                                   out_valid,
    input logic                                   out_stall,
    input logic signed [afc_pkg::ANSWER_BITS-1:0] answer,
    input logic [afc_pkg::STATUS_BITS-1:0]        status,
    input logic                                   stop_request
);

    // A stalled result beat stays offered
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid)
        else $error("result beat withdrawn while stalled");

    // No second result right after a taken one
    a_out_gap: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_stall |=> !out_valid)
        else $error("result beats back to back");

    // The input stays stalled after the final byte is taken
    a_final_stall: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall && end_of_message |=> in_stall [*2])
        else $error("input reopened too early after the final byte");

    // Errors answer zero
    a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (status != afc_pkg::STATUS_OK) |-> (answer == '0))
        else $error("nonzero answer with error status");

    // A stop message has no operator token
    a_stop_status: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && stop_request |-> (status == afc_pkg::STATUS_NO_OPERAND))
        else $error("stop message with unexpected status");

endmodule

bind ascii_formula_calculator afc_checker u_afc_checker (.*);
